>>> src/ldaas_pkg.sv
// shared types, codes and decode functions for the load accumulator address sequencer
`default_nettype none
package ldaas_pkg;

  localparam int BYTE_W = 8;
  localparam int ADDR_W = 16;
  localparam logic [ADDR_W-1:0] PAGE_MASK = 16'hFF00;

  localparam logic [3:0] MODE_IMM  = 4'd0;
  localparam logic [3:0] MODE_ZP   = 4'd1;
  localparam logic [3:0] MODE_ZPX  = 4'd2;
  localparam logic [3:0] MODE_ABS  = 4'd3;
  localparam logic [3:0] MODE_ABX  = 4'd4;
  localparam logic [3:0] MODE_ABY  = 4'd5;
  localparam logic [3:0] MODE_IDX  = 4'd6;
  localparam logic [3:0] MODE_IDY  = 4'd7;
  localparam logic [3:0] MODE_IDZ  = 4'd8;
  localparam logic [3:0] MODE_NONE = 4'd15;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  localparam logic [1:0] RES_READ  = 2'd0;
  localparam logic [1:0] RES_DONE  = 2'd1;
  localparam logic [1:0] RES_ERROR = 2'd2;

  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_LDA_ABX = 8'hBD;
  localparam logic [7:0] OP_LDA_ABY = 8'hB9;
  localparam logic [7:0] OP_LDA_IDX = 8'hA1;
  localparam logic [7:0] OP_LDA_IDY = 8'hB1;
  localparam logic [7:0] OP_LDA_IDZ = 8'hB2;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] opcode;
    logic [ADDR_W-1:0] program_counter;
    logic [BYTE_W-1:0] index_x;
    logic [BYTE_W-1:0] index_y;
    logic [BYTE_W-1:0] read_data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [ADDR_W-1:0] read_address;
    logic [BYTE_W-1:0] accumulator;
    logic              negative_flag;
    logic              zero_flag;
    logic [2:0]        cycle_count;
    logic [ADDR_W-1:0] next_program_counter;
  } out_word_t;

  typedef struct packed {
    logic [3:0]        mode;
    logic [2:0]        step;
    logic [BYTE_W-1:0] low_byte;
    logic [ADDR_W-1:0] base_address;
    logic [BYTE_W-1:0] saved_x;
    logic [BYTE_W-1:0] saved_y;
    logic [2:0]        cycle_total;
    logic [ADDR_W-1:0] pc;
  } seq_state_t;

  function automatic logic [3:0] decode_mode(input logic [7:0] op);
    logic [3:0] m;
    unique case (op)
      OP_LDA_IMM: m = MODE_IMM;
      OP_LDA_ZP:  m = MODE_ZP;
      OP_LDA_ZPX: m = MODE_ZPX;
      OP_LDA_ABS: m = MODE_ABS;
      OP_LDA_ABX: m = MODE_ABX;
      OP_LDA_ABY: m = MODE_ABY;
      OP_LDA_IDX: m = MODE_IDX;
      OP_LDA_IDY: m = MODE_IDY;
      OP_LDA_IDZ: m = MODE_IDZ;
      default:    m = MODE_NONE;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] base_cycles(input logic [3:0] m);
    logic [2:0] c;
    unique case (m)
      MODE_IMM: c = 3'd1;
      MODE_ZP:  c = 3'd2;
      MODE_IDX: c = 3'd5;
      MODE_IDY, MODE_IDZ: c = 3'd4;
      default:  c = 3'd3;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/ldaas_step.sv
// next-state and result logic for one input word of the sequencer
`default_nettype none
module ldaas_step (
  input  wire ldaas_pkg::seq_state_t st,
  input  wire ldaas_pkg::in_word_t   in_w,
  output ldaas_pkg::seq_state_t      st_nxt,
  output ldaas_pkg::out_word_t       res
);
  import ldaas_pkg::*;

  logic [3:0]        dec_mode;
  logic [BYTE_W-1:0] d;
  logic [ADDR_W-1:0] idx_base;
  logic [BYTE_W-1:0] idx_val;
  logic              idx_count;
  logic [ADDR_W-1:0] idx_sum;
  logic              idx_cross;
  logic [BYTE_W-1:0] ind_low;

  assign dec_mode = decode_mode(in_w.opcode);
  assign d        = in_w.read_data;

  // shared index adder for absolute and pointer modes
  always_comb begin
    if (st.mode == MODE_ABS || st.mode == MODE_ABX || st.mode == MODE_ABY) begin
      idx_base = {d, st.low_byte};
    end else begin
      idx_base = {d, st.base_address[BYTE_W-1:0]};
    end
    idx_val   = '0;
    idx_count = 1'b0;
    if (st.mode == MODE_ABX) begin
      idx_val   = st.saved_x;
      idx_count = 1'b1;
    end else if (st.mode == MODE_ABY || st.mode == MODE_IDY) begin
      idx_val   = st.saved_y;
      idx_count = 1'b1;
    end
  end

  assign idx_sum   = idx_base + {{(ADDR_W-BYTE_W){1'b0}}, idx_val};
  assign idx_cross = idx_count && ((idx_sum & PAGE_MASK) != (idx_base & PAGE_MASK));
  assign ind_low   = (st.mode == MODE_IDX) ? d + st.saved_x : d;

  always_comb begin
    st_nxt = st;
    res    = '0;
    if (in_w.kind == KIND_START) begin
      if (dec_mode == MODE_NONE) begin
        st_nxt.step     = '0;
        res.result_kind = RES_ERROR;
      end else begin
        st_nxt.mode         = dec_mode;
        st_nxt.pc           = in_w.program_counter;
        st_nxt.saved_x      = in_w.index_x;
        st_nxt.saved_y      = in_w.index_y;
        st_nxt.cycle_total  = base_cycles(dec_mode);
        st_nxt.low_byte     = '0;
        st_nxt.base_address = '0;
        st_nxt.step         = 3'd1;
        res.result_kind     = RES_READ;
        res.read_address    = in_w.program_counter;
      end
    end else if (st.step == '0 || st.mode > MODE_IDZ) begin
      res.result_kind = RES_ERROR;
    end else begin
      // default is completion; read arms override below
      res.result_kind          = RES_DONE;
      res.accumulator          = d;
      res.negative_flag        = d[BYTE_W-1];
      res.zero_flag            = (d == '0);
      res.cycle_count          = st.cycle_total;
      res.next_program_counter = st.pc + 16'd1;
      st_nxt.step              = '0;
      case (st.mode) inside
        MODE_IMM: begin
        end
        MODE_ZP, MODE_ZPX: begin
          if (st.step == 3'd1) begin
            res = '0;
            res.result_kind  = RES_READ;
            res.read_address = {8'h00, (st.mode == MODE_ZPX) ? d + st.saved_x : d};
            st_nxt.step      = st.step + 3'd1;
          end
        end
        MODE_ABS, MODE_ABX, MODE_ABY: begin
          if (st.step == 3'd1) begin
            res = '0;
            res.result_kind  = RES_READ;
            res.read_address = st.pc + 16'd1;
            st_nxt.low_byte  = d;
            st_nxt.step      = st.step + 3'd1;
          end else if (st.step == 3'd2) begin
            res = '0;
            res.result_kind     = RES_READ;
            res.read_address    = idx_sum;
            st_nxt.base_address = idx_sum;
            st_nxt.cycle_total  = st.cycle_total + {2'b00, idx_cross};
            st_nxt.step         = st.step + 3'd1;
          end else begin
            res.next_program_counter = st.pc + 16'd2;
          end
        end
        default: begin
          if (st.step == 3'd1) begin
            res = '0;
            res.result_kind  = RES_READ;
            res.read_address = {8'h00, ind_low};
            st_nxt.low_byte  = ind_low;
            st_nxt.step      = st.step + 3'd1;
          end else if (st.step == 3'd2) begin
            res = '0;
            res.result_kind     = RES_READ;
            res.read_address    = {8'h00, st.low_byte + 8'd1};
            st_nxt.base_address = {8'h00, d};
            st_nxt.step         = st.step + 3'd1;
          end else if (st.step == 3'd3) begin
            res = '0;
            res.result_kind     = RES_READ;
            res.read_address    = idx_sum;
            st_nxt.base_address = idx_sum;
            st_nxt.cycle_total  = st.cycle_total + {2'b00, idx_cross};
            st_nxt.step         = st.step + 3'd1;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/ldaas_outbuf.sv
// result register with skid stage for the output channel
`default_nettype none
module ldaas_outbuf (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  wire ldaas_pkg::out_word_t push_word,
  output logic                      full,
  output logic                      out_valid,
  input  wire                       out_stall,
  output ldaas_pkg::out_word_t      out_word
);
  import ldaas_pkg::*;

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t main_r, main_nxt;
  out_word_t skid_r, skid_nxt;
  logic      pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_word  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!main_valid_r || pop) begin
      main_nxt       = push_word;
      main_valid_nxt = push;
    end else if (push) begin
      skid_nxt       = push_word;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held with empty result register");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (!skid_valid_r && main_valid_r))
    else $error("skid word not moved on pop");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_stall) |=> (skid_valid_r && $stable(skid_r)))
    else $error("skid word changed while full");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!main_valid_r && !skid_valid_r))
    else $error("buffer not empty after reset");

endmodule
`default_nettype wire

>>> src/load_accumulator_address_sequencer.sv
// top level of the load accumulator address sequencer
// Usage: after the opcode byte is fetched, send a start word (in_kind 0) with
// the opcode, the operand address, X and Y. Every input word yields exactly one
// result word: a read request with out_read_address, a done word with the
// loaded value, N and Z flags, cycles spent and the next program counter, or
// an error word for an unknown opcode or data arriving while idle. Answer each
// read request with a data word (in_kind 1) carrying the byte read.
// Both channels are valid/stall; a word moves when valid is high and stall low.
// A result is registered in the result register, or in the skid stage if stalled.
// Throughput: one word per cycle while in_stall is low; the per-word decode and
// one 16-bit index add sit between the sequencer state and the result register.
// A skid stage behind the result register lets one more word in while the
// receiver stalls; in_stall rises only when that stage is occupied.
// A start word while busy abandons the instruction in progress.
// Reset (synchronous, active low) clears the sequencer state to idle and
// empties the output stages.
`default_nettype none
module load_accumulator_address_sequencer (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_kind,
  input  wire  [7:0]  in_opcode,
  input  wire  [15:0] in_program_counter,
  input  wire  [7:0]  in_index_x,
  input  wire  [7:0]  in_index_y,
  input  wire  [7:0]  in_read_data,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_read_address,
  output logic [7:0]  out_accumulator,
  output logic        out_negative_flag,
  output logic        out_zero_flag,
  output logic [2:0]  out_cycle_count,
  output logic [15:0] out_next_program_counter
);
  import ldaas_pkg::*;

  seq_state_t st_r, st_nxt;
  in_word_t   in_w;
  out_word_t  res;
  out_word_t  out_w;
  logic       accept;
  logic       full;

  assign in_w.kind            = in_kind;
  assign in_w.opcode          = in_opcode;
  assign in_w.program_counter = in_program_counter;
  assign in_w.index_x         = in_index_x;
  assign in_w.index_y         = in_index_y;
  assign in_w.read_data       = in_read_data;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  ldaas_step u_step (
    .st     (st_r),
    .in_w   (in_w),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  ldaas_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_word (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_w)
  );

  assign out_result_kind          = out_w.result_kind;
  assign out_read_address         = out_w.read_address;
  assign out_accumulator          = out_w.accumulator;
  assign out_negative_flag        = out_w.negative_flag;
  assign out_zero_flag            = out_w.zero_flag;
  assign out_cycle_count          = out_w.cycle_count;
  assign out_next_program_counter = out_w.next_program_counter;

  a_mode_known: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.step != '0) |-> (st_r.mode <= MODE_IDZ))
    else $error("busy with no valid addressing mode");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.result_kind == RES_DONE) |=> (st_r.step == '0))
    else $error("sequencer not idle after completion");

  a_stray_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_DATA && st_r.step == '0) |=> $stable(st_r))
    else $error("idle data word changed state");

endmodule
`default_nettype wire
